/* rtl/core/ggc_pkg.sv */
// Shared types and constants for the greedy graph coloring block.
package ggc_pkg;

    // default sizes
    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_EDGES_DEF = 1024;

    // item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_UNCOLORED = 2'd3;

    // register map
    localparam logic [1:0] ADDR_NODE_COUNT  = 2'd0;
    localparam logic [8:0] NODE_COUNT_RESET = 9'd1;

    // controller to datapath commands
    typedef struct packed {
        logic add;
        logic nop;
        logic run_init;
        logic run_empty;
        logic scan;
        logic search;
        logic run_finish;
        logic query;
        logic query_reply;
    } ggc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic found;
        logic last;
        logic n_zero;
    } ggc_sts_t;

endpackage

/* rtl/core/ggc_ram.sv */
// Generic single write, single read RAM with registered read data.
module ggc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/ggc_ctrl.sv */
// Controller state machine for the greedy graph coloring block.
module ggc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  ggc_pkg::ggc_sts_t sts,
    output ggc_pkg::ggc_cmd_t cmd,
    output logic              busy
);
    import ggc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_QUERY  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_SEARCH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_ADD:
                        begin
                            cmd.add = 1'b1;
                        end
                        KIND_RUN:
                        begin
                            if (sts.n_zero)
                            begin
                                cmd.run_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.run_init = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                        KIND_QUERY:
                        begin
                            cmd.query  = 1'b1;
                            state_next = S_QUERY;
                        end
                        default:
                        begin
                            cmd.nop = 1'b1;
                        end
                    endcase
                end
            end
            S_QUERY:
            begin
                cmd.query_reply = 1'b1;
                state_next      = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.found && sts.last)
                begin
                    cmd.run_finish = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (sts.found)
                begin
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/core/ggc_datapath.sv */
// Datapath: edge and color stores, scan pipeline, color search and results.
module ggc_datapath #(
    parameter int MAX_NODES = ggc_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = ggc_pkg::MAX_EDGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ggc_pkg::ggc_cmd_t cmd,
    output ggc_pkg::ggc_sts_t sts,
    input  logic [8:0]        node_count,
    input  logic [7:0]        node_a,
    input  logic [7:0]        node_b,
    output logic              result_valid,
    output logic [1:0]        status,
    output logic [7:0]        node_color,
    output logic [8:0]        colors_used
);
    import ggc_pkg::*;

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int CAW = $clog2(MAX_NODES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int UW  = $clog2(MAX_NODES + 2);

    // registers
    logic [ETW-1:0]     edge_total_reg, edge_total_next;
    logic [ETW-1:0]     e_reg, e_next;
    logic [NW-1:0]      i_reg, i_next;
    logic [NW-1:0]      c_reg, c_next;
    logic [UW-1:0]      used_reg, used_next;
    logic [MAX_NODES:0] taken_reg, taken_next;
    logic               p1_reg, p1_next;
    logic               p2_reg, p2_next;
    logic [NW-1:0]      colored_reg, colored_next;
    logic               valid_reg, valid_next;
    logic [7:0]         qa_reg, qa_next;
    logic               res_valid_reg, res_valid_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [7:0]         res_color_reg, res_color_next;
    logic [8:0]         res_used_reg, res_used_next;

    // RAM ports
    logic               edge_we, edge_re;
    logic [15:0]        edge_rdata;
    logic               color_we, color_re;
    logic [CAW-1:0]     color_raddr;
    logic [NW-1:0]      color_rdata;

    logic [NW-1:0]      n_c;
    logic               add_oor, add_full;
    logic [7:0]         ea, eb, other;
    logic               hit;
    logic [UW-1:0]      used_max;

    // active node count, limited to the store size
    assign n_c = (32'(node_count) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count);

    assign add_oor  = (32'(node_a) >= 32'(n_c)) || (32'(node_b) >= 32'(n_c));
    assign add_full = (32'(edge_total_reg) >= MAX_EDGES);
    assign edge_we  = cmd.add && !add_oor && !add_full;

    // scan stage 1: edge read
    assign edge_re = cmd.scan && (e_reg != edge_total_reg);

    // scan stage 2: neighbor test, color read of the neighbor
    assign ea    = edge_rdata[15:8];
    assign eb    = edge_rdata[7:0];
    assign other = (32'(ea) == 32'(i_reg)) ? eb : ea;
    assign hit   = p1_reg && ((32'(ea) == 32'(i_reg)) || (32'(eb) == 32'(i_reg)))
                   && (32'(other) < 32'(i_reg));

    assign color_re    = hit || cmd.query;
    assign color_raddr = cmd.query ? CAW'(node_a) : CAW'(other);
    assign color_we    = cmd.search && sts.found;

    assign used_max = (used_reg > (UW'(c_reg) + UW'(1))) ? used_reg
                                                         : (UW'(c_reg) + UW'(1));

    // status to controller
    assign sts.scan_done = (e_reg == edge_total_reg) && !p1_reg && !p2_reg;
    assign sts.found     = !taken_reg[c_reg] || (c_reg == NW'(MAX_NODES));
    assign sts.last      = (i_reg == (n_c - NW'(1)));
    assign sts.n_zero    = (n_c == '0);

    ggc_ram #(
        .WIDTH (16),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (EAW'(edge_total_reg)),
        .wdata ({node_a, node_b}),
        .re    (edge_re),
        .raddr (EAW'(e_reg)),
        .rdata (edge_rdata)
    );

    ggc_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .waddr (CAW'(i_reg)),
        .wdata (c_reg),
        .re    (color_re),
        .raddr (color_raddr),
        .rdata (color_rdata)
    );

    // next state of the datapath
    always_comb
    begin
        edge_total_next = edge_total_reg;
        e_next          = e_reg;
        i_next          = i_reg;
        c_next          = c_reg;
        used_next       = used_reg;
        taken_next      = taken_reg;
        p1_next         = edge_re;
        p2_next         = hit;
        colored_next    = colored_reg;
        valid_next      = valid_reg;
        qa_next         = qa_reg;
        res_valid_next  = 1'b0;
        res_status_next = ST_OK;
        res_color_next  = '0;
        res_used_next   = '0;

        // edge load
        if (cmd.add)
        begin
            res_valid_next = 1'b1;
            if (add_oor)
            begin
                res_status_next = ST_RANGE;
            end
            else if (add_full)
            begin
                res_status_next = ST_FULL;
            end
            else
            begin
                edge_total_next = edge_total_reg + ETW'(1);
            end
        end

        // unknown kind
        if (cmd.nop)
        begin
            res_valid_next = 1'b1;
        end

        // run setup
        if (cmd.run_init)
        begin
            e_next     = '0;
            i_next     = '0;
            c_next     = '0;
            used_next  = '0;
            taken_next = '0;
        end

        // scan: advance edge address, mark neighbor colors
        if (edge_re)
        begin
            e_next = e_reg + ETW'(1);
        end
        if (p2_reg)
        begin
            taken_next[color_rdata] = 1'b1;
        end

        // first free color search
        if (cmd.search)
        begin
            if (!sts.found)
            begin
                c_next = c_reg + NW'(1);
            end
            else
            begin
                used_next = used_max;
                if (!sts.last)
                begin
                    i_next     = i_reg + NW'(1);
                    e_next     = '0;
                    c_next     = '0;
                    taken_next = '0;
                end
            end
        end

        // run end: record coloring, empty edge store
        if (cmd.run_finish || cmd.run_empty)
        begin
            colored_next    = n_c;
            valid_next      = 1'b1;
            edge_total_next = '0;
            res_valid_next  = 1'b1;
            res_used_next   = cmd.run_empty ? 9'd0 : 9'(used_max);
        end

        // query
        if (cmd.query)
        begin
            qa_next = node_a;
        end
        if (cmd.query_reply)
        begin
            res_valid_next = 1'b1;
            if (!valid_reg)
            begin
                res_status_next = ST_UNCOLORED;
            end
            else if (32'(qa_reg) >= 32'(n_c))
            begin
                res_status_next = ST_RANGE;
            end
            else if (32'(qa_reg) >= 32'(colored_reg))
            begin
                res_status_next = ST_UNCOLORED;
            end
            else
            begin
                res_color_next = 8'(color_rdata);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
            e_reg          <= '0;
            i_reg          <= '0;
            c_reg          <= '0;
            used_reg       <= '0;
            taken_reg      <= '0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            colored_reg    <= '0;
            valid_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            edge_total_reg <= edge_total_next;
            e_reg          <= e_next;
            i_reg          <= i_next;
            c_reg          <= c_next;
            used_reg       <= used_next;
            taken_reg      <= taken_next;
            p1_reg         <= p1_next;
            p2_reg         <= p2_next;
            colored_reg    <= colored_next;
            valid_reg      <= valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        qa_reg         <= qa_next;
        res_status_reg <= res_status_next;
        res_color_reg  <= res_color_next;
        res_used_reg   <= res_used_next;
    end

    assign result_valid = res_valid_reg;
    assign status       = res_status_reg;
    assign node_color   = res_color_reg;
    assign colors_used  = res_used_reg;

endmodule

/* rtl/core/greedy_graph_coloring.sv */
// Greedy first-fit graph coloring: top level with register port and checks.
// Edge load, unknown kind and a run with node_count zero: strobe the cycle after.
// Query: the accept cycle reads the color store, S_QUERY registers the result.
// Run: accept cycle, then per node a scan over the edge store through its single read
//   port and a first-fit search over the colors. busy stays high meanwhile; the strobe
//   follows the last search cycle.
// Results cannot be stalled. Reset clears the edge count and the coloring flag;
// the stores need no clearing pass.
module greedy_graph_coloring #(
    parameter int MAX_NODES = ggc_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = ggc_pkg::MAX_EDGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  node_a,
    input  logic [7:0]  node_b,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [7:0]  node_color,
    output logic [8:0]  colors_used,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ggc_pkg::*;

    ggc_cmd_t   cmd;
    ggc_sts_t   sts;
    logic [8:0] node_count_reg, node_count_next;

    // register write
    always_comb
    begin
        node_count_next = node_count_reg;
        if (psel && penable && pwrite && (paddr == ADDR_NODE_COUNT))
        begin
            node_count_next = pwdata[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    // register read
    assign prdata = (paddr == ADDR_NODE_COUNT) ? {23'd0, node_count_reg} : 32'd0;
    assign pready = 1'b1;

    ggc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ggc_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .node_count   (node_count_reg),
        .node_a       (node_a),
        .node_b       (node_b),
        .result_valid (result_valid),
        .status       (status),
        .node_color   (node_color),
        .colors_used  (colors_used)
    );

`ifndef SYNTHESIS
    // an edge load answers in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_ADD)) |=> result_valid)
        else $error("edge load transfer without result");

    // a query passes through busy, then answers
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_QUERY)) |=> (busy ##1 result_valid))
        else $error("query transfer timing broken");

    // a color is only reported with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((node_color == 8'd0) || (status == ST_OK)))
        else $error("color reported with error status");
`endif

endmodule
